// File: hdl/abd_pkg.sv
// shared types, codes and a helper function for the archive block deobfuscator
// no dependencies; imported by abd_classifier and archive_block_deobfuscator
package abd_pkg;

  // decode mode register codes
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_HEADER = 2'd1;
  localparam logic [1:0] MODE_MIXED  = 2'd2;

  // register indexes on the configuration port
  localparam logic CFG_DECODE_MODE  = 1'b0;
  localparam logic CFG_ENTRY_LENGTH = 1'b1;

  localparam int unsigned LEN_W = 31;
  localparam int unsigned GAP_W = 5;

  // per-block result code
  typedef enum logic [1:0] {
    ACT_PLAIN   = 2'd0,
    ACT_DES     = 2'd1,
    ACT_SHUFFLE = 2'd2
  } action_t;

  // decimal thresholds for the digit count of a 31-bit length
  localparam logic [LEN_W-1:0] POW10 [9] = '{
    31'd10, 31'd100, 31'd1000, 31'd10000, 31'd100000,
    31'd1000000, 31'd10000000, 31'd100000000, 31'd1000000000
  };

  // des gap from the decimal digit count of the entry length
  function automatic logic [GAP_W-1:0] gap_of_length(input logic [LEN_W-1:0] len);
    logic [3:0]       digits;
    logic [GAP_W-1:0] gap;
    digits = 4'd1;
    for (int k = 0; k < 9; k++) begin
      if (len >= POW10[k]) begin
        digits = digits + 4'd1;
      end
    end
    if (digits < 4'd3) begin
      gap = 5'd1;
    end else if (digits < 4'd5) begin
      gap = {1'b0, digits} + 5'd1;
    end else if (digits < 4'd7) begin
      gap = {1'b0, digits} + 5'd9;
    end else begin
      gap = {1'b0, digits} + 5'd15;
    end
    return gap;
  endfunction

endpackage

// File: hdl/abd_unshuffle.sv
// byte de-shuffle: fixed byte permutation plus a symmetric swap on byte 7
// no dependencies
module abd_unshuffle (
  input  logic [63:0] din,
  output logic [63:0] dout
);

  // symmetric value swap for the top byte
  function automatic logic [7:0] swap_value(input logic [7:0] v);
    logic [7:0] r;
    case (v)
      8'h00:   r = 8'h2B;
      8'h2B:   r = 8'h00;
      8'h01:   r = 8'h68;
      8'h68:   r = 8'h01;
      8'h48:   r = 8'h77;
      8'h77:   r = 8'h48;
      8'h60:   r = 8'hFF;
      8'hFF:   r = 8'h60;
      8'h6C:   r = 8'h80;
      8'h80:   r = 8'h6C;
      8'hB9:   r = 8'hC0;
      8'hC0:   r = 8'hB9;
      8'hEB:   r = 8'hFE;
      8'hFE:   r = 8'hEB;
      default: r = v;
    endcase
    return r;
  endfunction

  // out bytes 0..6 take in bytes 3,4,6,0,1,2,5
  assign dout[7:0]   = din[31:24];
  assign dout[15:8]  = din[39:32];
  assign dout[23:16] = din[55:48];
  assign dout[31:24] = din[7:0];
  assign dout[39:32] = din[15:8];
  assign dout[47:40] = din[23:16];
  assign dout[55:48] = din[47:40];
  assign dout[63:56] = swap_value(din[63:56]);

endmodule

// File: hdl/abd_classifier.sv
// block classifier: buffer counters and per-block action decision
// depends on abd_pkg
module abd_classifier #(
  parameter int unsigned HEADER_BLOCKS = 20,
  parameter int unsigned BC_W          = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       first,
  input  logic [1:0]                 mode,
  input  logic [abd_pkg::GAP_W-1:0]  gap,
  output abd_pkg::action_t           action
);
  import abd_pkg::*;

  logic [BC_W-1:0]  block_count_r, block_count_nxt, bc_eff;
  logic [GAP_W-1:0] des_phase_r, des_phase_nxt, dp_eff;
  logic [2:0]       plain_phase_r, plain_phase_nxt, pp_eff;
  logic             plain_seen_r, plain_seen_nxt, ps_eff;
  logic [GAP_W:0]   dp_sum;
  logic             in_header;
  logic             des_hit;
  logic             plain_step;

  // a first-block mark restarts every counter before this block
  assign bc_eff = first ? '0 : block_count_r;
  assign dp_eff = first ? '0 : des_phase_r;
  assign pp_eff = first ? '0 : plain_phase_r;
  assign ps_eff = first ? 1'b0 : plain_seen_r;

  assign in_header = bc_eff < BC_W'(HEADER_BLOCKS);
  assign des_hit   = dp_eff == '0;

  // action decision per mode; unused mode code behaves as plain
  always_comb begin
    action     = ACT_PLAIN;
    plain_step = 1'b0;
    unique case (mode)
      MODE_HEADER: begin
        if (in_header) begin
          action = ACT_DES;
        end
      end
      MODE_MIXED: begin
        if (in_header || des_hit) begin
          action = ACT_DES;
        end else begin
          plain_step = 1'b1;
          if (ps_eff && pp_eff == 3'd0) begin
            action = ACT_SHUFFLE;
          end
        end
      end
      default: begin
        action = ACT_PLAIN;
      end
    endcase
  end

  // counter next values
  assign dp_sum = {1'b0, dp_eff} + (GAP_W + 1)'(1);
  always_comb begin
    block_count_nxt = in_header ? bc_eff + BC_W'(1) : bc_eff;
    des_phase_nxt   = (dp_sum >= {1'b0, gap}) ? '0 : dp_sum[GAP_W-1:0];
    plain_phase_nxt = pp_eff;
    plain_seen_nxt  = ps_eff;
    if (plain_step) begin
      plain_seen_nxt  = 1'b1;
      plain_phase_nxt = (pp_eff >= 3'd6) ? 3'd0 : pp_eff + 3'd1;
    end
  end

  // counters advance once per classified block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
      des_phase_r   <= '0;
      plain_phase_r <= '0;
      plain_seen_r  <= 1'b0;
    end else if (step) begin
      block_count_r <= block_count_nxt;
      des_phase_r   <= des_phase_nxt;
      plain_phase_r <= plain_phase_nxt;
      plain_seen_r  <= plain_seen_nxt;
    end
  end

endmodule

// File: hdl/archive_block_deobfuscator.sv
// archive block deobfuscator, top level: config registers, input and result stages
// depends on abd_pkg, abd_classifier, abd_unshuffle
// a block passes the registered input stage and then the registered result stage
// before its result transaction; a full result stage holds while out_tready is low
// throughput: one block per cycle unless out_tready stalls; counters update per moved block
// reset (synchronous, rst_n low): both stages empty, counters zero, plain mode, gap of length zero
module archive_block_deobfuscator #(
  parameter int unsigned HEADER_BLOCKS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,   // block_data
  input  logic                      in_tuser,   // first_block
  // result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [63:0]               out_tdata,  // result_data
  output logic [1:0]                out_tuser,  // action
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [abd_pkg::LEN_W-1:0] cfg_data
);
  import abd_pkg::*;

  localparam int unsigned BC_W = $clog2(HEADER_BLOCKS + 1);

  logic [1:0]       decode_mode_r;
  logic [GAP_W-1:0] gap_r;
  logic             s1_valid_r;
  logic [63:0]      s1_data_r;
  logic             s1_first_r;
  logic             out_valid_r;
  logic [63:0]      out_data_r;
  action_t          out_action_r;
  logic             out_free;
  logic             s1_move;
  action_t          action;
  logic [63:0]      shuffled;
  logic [63:0]      result_nxt;

  // configuration writes; the des gap is derived once when the length is written
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= MODE_PLAIN;
      gap_r         <= gap_of_length('0);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DECODE_MODE:  decode_mode_r <= cfg_data[1:0];
        CFG_ENTRY_LENGTH: gap_r         <= gap_of_length(cfg_data);
        default:          decode_mode_r <= decode_mode_r;
      endcase
    end
  end

  // stage handshakes
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r  <= in_tdata;
      s1_first_r <= in_tuser;
    end
  end

  // classification and de-shuffle
  abd_classifier #(
    .HEADER_BLOCKS (HEADER_BLOCKS),
    .BC_W          (BC_W)
  ) u_classifier (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_move),
    .first  (s1_first_r),
    .mode   (decode_mode_r),
    .gap    (gap_r),
    .action (action)
  );

  abd_unshuffle u_unshuffle (
    .din  (s1_data_r),
    .dout (shuffled)
  );

  assign result_nxt = (action == ACT_SHUFFLE) ? shuffled : s1_data_r;

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r   <= result_nxt;
      out_action_r <= action;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_action_r;

endmodule
